// ===== rtl/core/oaht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, codes and defaults for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    localparam int KEY_IN_W   = 32;
    localparam int HASH_W     = 32;
    localparam int SLOT_OUT_W = 10;
    localparam int COUNT_W    = 11;
    localparam int SIZE_REG_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int DIV_CNT_W  = $clog2(HASH_W);

    localparam logic [SIZE_REG_W-1:0] TABLE_SIZE_RESET = 11'd1021;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TABLE_SIZE = 1'b0,
        REG_PROBE_MODE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        MARK_EMPTY    = 2'd0,
        MARK_OCCUPIED = 2'd1,
        MARK_DELETED  = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_START,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic clr_step;
        logic div_step;
        logic probe_init;
        logic probe_rd;
        logic advance;
        logic wr_insert;
        logic wr_delete;
        logic set_result;
        logic res_ok;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic    in_valid;
        logic    clr_done;
        logic    div_last;
        logic    slot_empty;
        logic    key_hit;
        logic    probe_last;
        opcode_t op;
        logic    out_busy;
    } status_t;

endpackage

// ===== rtl/core/oaht_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_if
// Request and result channels of the hash table.
// ----------------------------------------------------------------------------
interface oaht_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [31:0] entry_key;
    logic [31:0] hash_value;

    modport source (output valid, opcode, entry_key, hash_value, input ready);
    modport sink   (input valid, opcode, entry_key, hash_value, output ready);
endinterface

interface oaht_out_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [9:0]  slot_index;
    logic [10:0] entry_count;

    modport source (output valid, success, slot_index, entry_count, input ready);
    modport sink   (input valid, success, slot_index, entry_count, output ready);
endinterface

// ===== rtl/core/oaht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/oaht_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer: clearing pass, home slot division, probe loop, result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  oaht_pkg::status_t status,
    output oaht_pkg::cmd_t    cmd
);

    import oaht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.probe_init = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.op == OP_INSERT && status.slot_empty)
                begin
                    cmd.wr_insert  = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.res_ok     = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (status.op == OP_REMOVE && status.slot_empty)
                begin
                    cmd.set_result = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (status.op == OP_REMOVE && status.key_hit)
                begin
                    cmd.wr_delete  = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.res_ok     = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (status.probe_last)
                begin
                    cmd.set_result = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> state_reg == ST_CLEAR || state_reg == ST_IDLE)
        else $error("clearing pass left early");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.clr_step, cmd.wr_insert, cmd.wr_delete}) <= 1)
        else $error("conflicting table writes");

    a_result_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_result |=> state_reg == ST_DONE)
        else $error("result not handed on");

endmodule

// ===== rtl/core/oaht_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: config registers, modulo unit, probe stepping, slot RAM, result.
// ----------------------------------------------------------------------------
module oaht_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    oaht_in_if.sink                             in_ch,
    oaht_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [oaht_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [oaht_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  oaht_pkg::cmd_t                      cmd,
    output oaht_pkg::status_t                   status
);

    import oaht_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int SW = IW + 1;
    localparam int EW = 2 + KEY_WIDTH;

    logic [SIZE_REG_W-1:0] table_size_reg;
    logic                  probe_mode_reg;
    logic [SW-1:0]         size_eff;

    logic                  op_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [SW-1:0]         rem_reg;
    logic [SW:0]           rem_shift;
    logic [SW:0]           rem_trial;

    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         step_reg;
    logic [SW-1:0]         probe_cnt_reg;
    logic [SW-1:0]         idx_sum;
    logic [SW-1:0]         step_sum;

    logic [SW-1:0]         clr_cnt_reg;
    logic [SW-1:0]         count_reg;
    logic                  res_ok_reg;
    logic [IW-1:0]         res_slot_reg;

    logic                  out_valid_reg;
    logic                  out_success_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    logic                  ram_we;
    logic [IW-1:0]         ram_addr;
    logic [EW-1:0]         ram_wdata;
    logic [EW-1:0]         ram_rdata;
    mark_t                 rd_mark;
    logic [KEY_WIDTH-1:0]  rd_key;

    always_comb
    begin
        if (32'(table_size_reg) < 32'd2)
        begin
            size_eff = SW'(2);
        end
        else if (32'(table_size_reg) > 32'(TABLE_DEPTH))
        begin
            size_eff = SW'(TABLE_DEPTH);
        end
        else
        begin
            size_eff = SW'(table_size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
            probe_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE_SIZE: table_size_reg <= cfg_data;
                REG_PROBE_MODE: probe_mode_reg <= cfg_data[0];
                default:        probe_mode_reg <= probe_mode_reg;
            endcase
        end
    end

    // restoring division, one hash bit per cycle
    assign rem_shift = {rem_reg, hash_reg[HASH_W-1]};
    assign rem_trial = rem_shift - {1'b0, size_eff};

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && cmd.in_ready)
        begin
            op_reg      <= in_ch.opcode;
            key_reg     <= KEY_WIDTH'(in_ch.entry_key);
            hash_reg    <= in_ch.hash_value;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            hash_reg    <= {hash_reg[HASH_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (!rem_trial[SW])
            begin
                rem_reg <= rem_trial[SW-1:0];
            end
            else
            begin
                rem_reg <= rem_shift[SW-1:0];
            end
        end
    end

    // linear steps of one, or with probe_mode set, quadratic offsets stepped by odd increments mod size
    assign idx_sum  = SW'(idx_reg) + SW'(step_reg);
    assign step_sum = SW'(step_reg) + SW'(2);

    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            idx_reg       <= IW'(rem_reg);
            step_reg      <= IW'(1);
            probe_cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
            if (idx_sum >= size_eff)
            begin
                idx_reg <= IW'(idx_sum - size_eff);
            end
            else
            begin
                idx_reg <= IW'(idx_sum);
            end
            if (probe_mode_reg)
            begin
                if (step_sum >= size_eff)
                begin
                    step_reg <= IW'(step_sum - size_eff);
                end
                else
                begin
                    step_reg <= IW'(step_sum);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign ram_we   = cmd.clr_step | cmd.wr_insert | cmd.wr_delete;
    assign ram_addr = cmd.clr_step ? clr_cnt_reg[IW-1:0] : idx_reg;
    assign rd_mark  = mark_t'(ram_rdata[EW-1 -: 2]);
    assign rd_key   = ram_rdata[KEY_WIDTH-1:0];

    always_comb
    begin
        if (cmd.wr_insert)
        begin
            ram_wdata = {MARK_OCCUPIED, key_reg};
        end
        else if (cmd.wr_delete)
        begin
            ram_wdata = {MARK_DELETED, rd_key};
        end
        else
        begin
            ram_wdata = {MARK_EMPTY, {KEY_WIDTH{1'b0}}};
        end
    end

    oaht_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.set_result && cmd.res_ok)
        begin
            if (op_reg == OP_INSERT)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            res_ok_reg   <= cmd.res_ok;
            res_slot_reg <= cmd.res_ok ? idx_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_success_reg <= res_ok_reg;
            out_slot_reg    <= SLOT_OUT_W'(res_slot_reg);
            out_count_reg   <= COUNT_W'(count_reg);
        end
    end

    assign in_ch.ready        = cmd.in_ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.success     = out_success_reg;
    assign out_ch.slot_index  = out_slot_reg;
    assign out_ch.entry_count = out_count_reg;

    assign status.in_valid   = in_ch.valid;
    assign status.clr_done   = (clr_cnt_reg == SW'(TABLE_DEPTH - 1));
    assign status.div_last   = (div_cnt_reg == DIV_CNT_W'(HASH_W - 1));
    assign status.slot_empty = (rd_mark == MARK_EMPTY);
    assign status.key_hit    = (rd_mark == MARK_OCCUPIED) && (rd_key == key_reg);
    assign status.probe_last = (probe_cnt_reg == size_eff - 1'b1);
    assign status.op         = opcode_t'(op_reg);
    assign status.out_busy   = out_valid_reg & ~out_ch.ready;

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> rem_reg < size_eff)
        else $error("remainder out of range");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_rd |-> SW'(idx_reg) < size_eff && probe_cnt_reg < size_eff)
        else $error("probe outside table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SW'(TABLE_DEPTH))
        else $error("occupied count too large");

endmodule

// ===== rtl/core/open_addressing_hash_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top
// Key table with linear or quadratic probing, insert and remove requests.
//
//  channel  dir  words carried
//  in_ch    in   opcode, entry_key, hash_value
//  out_ch   out  success, slot_index, entry_count
//  cfg_*    in   table_size (index 0), probe_mode (index 1)
//
// a request runs the bit-serial hash modulo over the 32-bit hash value,
// then one RAM read and one check per probe on the single slot RAM port
// after reset a clearing pass empties all slots
// one request in flight; a finished word waits in the output register
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top #(
    parameter int TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = oaht_pkg::DEF_KEY_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    oaht_in_if.sink                         in_ch,
    oaht_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oaht_pkg::CFG_DATA_W-1:0] cfg_data
);

    import oaht_pkg::*;

    cmd_t    cmd;
    status_t status;

    oaht_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    oaht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
